FILE: src/led_blink_code_sequencer_assert.svh
// assertion macros shared by the led blink code sequencer rtl
`ifndef LED_BLINK_CODE_SEQUENCER_ASSERT_SVH
`define LED_BLINK_CODE_SEQUENCER_ASSERT_SVH

// antecedent true implies consequent in the same cycle
`define LBCS_ASSERT_IMPL(label, ck, rn, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// antecedent true implies consequent in the next cycle
`define LBCS_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/lbcs_pkg.sv
// types and constants of the led blink code sequencer
package lbcs_pkg;

	localparam int DUR_W      = 16;
	localparam int LEN_W      = 5;
	localparam int SYM_W      = 32;
	localparam int SYM_SLOTS  = SYM_W / 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// symbol codes in the pattern word, code three reads as blank
	localparam logic [1:0] SYM_BLANK = 2'd0;
	localparam logic [1:0] SYM_DOT   = 2'd1;
	localparam logic [1:0] SYM_DASH  = 2'd2;

	typedef enum logic [1:0] {
		PH_ON     = 2'd0,
		PH_GAP    = 2'd1,
		PH_REPEAT = 2'd2
	} phase_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DOT_TICKS       = 3'd0,
		REG_DASH_TICKS      = 3'd1,
		REG_GAP_TICKS       = 3'd2,
		REG_REPEAT_TICKS    = 3'd3,
		REG_PATTERN_LENGTH  = 3'd4,
		REG_PATTERN_SYMBOLS = 3'd5
	} reg_idx_t;

	localparam logic [DUR_W-1:0] DOT_TICKS_RST       = 16'd200;
	localparam logic [DUR_W-1:0] DASH_TICKS_RST      = 16'd600;
	localparam logic [DUR_W-1:0] GAP_TICKS_RST       = 16'd200;
	localparam logic [DUR_W-1:0] REPEAT_TICKS_RST    = 16'd2000;
	localparam logic [LEN_W-1:0] PATTERN_LENGTH_RST  = 5'd5;
	localparam logic [SYM_W-1:0] PATTERN_SYMBOLS_RST = 32'd597;

	// one result word
	typedef struct packed {
		logic       led_on;
		logic [3:0] symbol_index;
		phase_t     phase;
	} res_t;

endpackage

FILE: src/lbcs_step.sv
// one tick of the blink sequencer: settle the position, form the result, count the tick
module lbcs_step #(
	parameter int MAX_SYMBOLS = 16,
	parameter int TICK_WIDTH  = 16
) (
	input  logic                                                   restart,
	input  lbcs_pkg::phase_t                                       phase_cur,
	input  logic [$clog2(MAX_SYMBOLS > 1 ? MAX_SYMBOLS : 2)-1:0]   pos_cur,
	input  logic [TICK_WIDTH-1:0]                                  cnt_cur,
	input  logic [lbcs_pkg::DUR_W-1:0]                             dot_ticks,
	input  logic [lbcs_pkg::DUR_W-1:0]                             dash_ticks,
	input  logic [lbcs_pkg::DUR_W-1:0]                             gap_ticks,
	input  logic [lbcs_pkg::DUR_W-1:0]                             repeat_ticks,
	input  logic [lbcs_pkg::LEN_W-1:0]                             pattern_length,
	input  logic [lbcs_pkg::SYM_W-1:0]                             pattern_symbols,
	output lbcs_pkg::res_t                                         res,
	output lbcs_pkg::phase_t                                       phase_nxt,
	output logic [$clog2(MAX_SYMBOLS > 1 ? MAX_SYMBOLS : 2)-1:0]   pos_nxt,
	output logic [TICK_WIDTH-1:0]                                  cnt_nxt
);

	localparam int PW = $clog2(MAX_SYMBOLS > 1 ? MAX_SYMBOLS : 2);
	localparam int LW = $clog2(MAX_SYMBOLS + 1);
	localparam int KW = $clog2(2 * MAX_SYMBOLS + 1);
	localparam int DW = (TICK_WIDTH < lbcs_pkg::DUR_W) ? TICK_WIDTH : lbcs_pkg::DUR_W;
	localparam int SETTLE_STEPS = 2 * MAX_SYMBOLS + 4;

	typedef struct packed {
		lbcs_pkg::phase_t ph;
		logic [PW-1:0]    pos;
	} loc_t;

	logic [TICK_WIDTH-1:0] dot_dur, dash_dur, gap_dur, rep_dur;
	logic                  dot_nz, dash_nz, gap_nz, rep_nz;
	logic [LW-1:0]         len;
	logic                  len_zero;
	logic [PW-1:0]         last_pos;
	logic [MAX_SYMBOLS-1:0] is_dot, is_dash, nz_on, ge_mask, gt_mask, from_vec;
	loc_t                  s_loc, a_loc, srch_loc, f_loc, nf_loc, adv_f_loc;
	logic [TICK_WIDTH-1:0] s_cnt, cur_dur, f_cnt, f_dur, inc_cnt;
	logic                  stay, srch_found, found;
	logic                  hit_from, hit_zero;
	logic [PW-1:0]         idx_from, idx_zero;
	logic [KW-1:0]         wrap_off [MAX_SYMBOLS+1];
	logic [KW-1:0]         two_len, k0, kf;
	logic [KW:0]           k_sum, k_len;

	function automatic loc_t advance_loc(loc_t cur, logic [LW-1:0] n);
		loc_t nxt;
		nxt = cur;
		unique case (cur.ph)
			lbcs_pkg::PH_ON: begin
				nxt.ph = lbcs_pkg::PH_GAP;
			end
			lbcs_pkg::PH_GAP: begin
				if ((LW+1)'(cur.pos) + (LW+1)'(1) < (LW+1)'(n)) begin
					nxt.ph  = lbcs_pkg::PH_ON;
					nxt.pos = cur.pos + PW'(1);
				end else begin
					nxt.ph = lbcs_pkg::PH_REPEAT;
				end
			end
			default: begin
				nxt.ph  = lbcs_pkg::PH_ON;
				nxt.pos = '0;
			end
		endcase
		return nxt;
	endfunction

	function automatic logic [PW-1:0] lowest_set(logic [MAX_SYMBOLS-1:0] v);
		logic [PW-1:0] r;
		r = '0;
		for (int p = MAX_SYMBOLS - 1; p >= 0; p--) begin
			if (v[p]) begin
				r = PW'(p);
			end
		end
		return r;
	endfunction

	assign dot_dur  = TICK_WIDTH'(dot_ticks[DW-1:0]);
	assign dash_dur = TICK_WIDTH'(dash_ticks[DW-1:0]);
	assign gap_dur  = TICK_WIDTH'(gap_ticks[DW-1:0]);
	assign rep_dur  = TICK_WIDTH'(repeat_ticks[DW-1:0]);
	assign dot_nz   = |dot_dur;
	assign dash_nz  = |dash_dur;
	assign gap_nz   = |gap_dur;
	assign rep_nz   = |rep_dur;

	assign len      = (32'(pattern_length) > MAX_SYMBOLS) ? LW'(MAX_SYMBOLS) : LW'(pattern_length);
	assign len_zero = (len == '0);
	assign last_pos = PW'(len - LW'(1));
	assign two_len  = KW'({len, 1'b0});

	for (genvar g = 0; g < MAX_SYMBOLS; g++) begin : g_sym
		if (g < lbcs_pkg::SYM_SLOTS) begin : g_slot
			assign is_dot[g]  = (pattern_symbols[2*g +: 2] == lbcs_pkg::SYM_DOT);
			assign is_dash[g] = (pattern_symbols[2*g +: 2] == lbcs_pkg::SYM_DASH);
		end else begin : g_blank
			assign is_dot[g]  = 1'b0;
			assign is_dash[g] = 1'b0;
		end
		assign nz_on[g]   = (LW'(g) < len) && ((is_dot[g] && dot_nz) || (is_dash[g] && dash_nz));
		assign ge_mask[g] = (a_loc.pos <= PW'(g));
		assign gt_mask[g] = (a_loc.pos < PW'(g));
	end

	// position offset after a full run of skipped phases, per pattern length
	assign wrap_off[0] = '0;
	for (genvar g = 1; g <= MAX_SYMBOLS; g++) begin : g_wrap
		localparam int WRAP = SETTLE_STEPS % (2 * g + 1);
		assign wrap_off[g] = KW'(WRAP);
	end

	always_comb begin
		if (restart) begin
			s_loc.ph  = lbcs_pkg::PH_ON;
			s_loc.pos = '0;
			s_cnt     = '0;
		end else begin
			s_loc.ph  = phase_cur;
			s_loc.pos = pos_cur;
			s_cnt     = cnt_cur;
		end
		// position beyond a shortened pattern starts over
		if (LW'(s_loc.pos) >= len) begin
			s_loc.ph  = lbcs_pkg::PH_ON;
			s_loc.pos = '0;
			s_cnt     = '0;
		end
	end

	always_comb begin
		unique case (s_loc.ph)
			lbcs_pkg::PH_ON:     cur_dur = is_dot[s_loc.pos] ? dot_dur :
			                               (is_dash[s_loc.pos] ? dash_dur : '0);
			lbcs_pkg::PH_GAP:    cur_dur = gap_dur;
			lbcs_pkg::PH_REPEAT: cur_dur = rep_dur;
			default:             cur_dur = '0;
		endcase
	end

	assign stay  = (s_cnt < cur_dur);
	assign a_loc = advance_loc(s_loc, len);

	assign from_vec = nz_on & ((a_loc.ph == lbcs_pkg::PH_GAP) ? gt_mask : ge_mask);
	assign hit_from = |from_vec;
	assign hit_zero = |nz_on;
	assign idx_from = lowest_set(from_vec);
	assign idx_zero = lowest_set(nz_on);

	// first phase with a nonzero duration, starting at the advanced position
	always_comb begin
		srch_found = 1'b1;
		srch_loc   = a_loc;
		if (gap_nz) begin
			unique case (a_loc.ph)
				lbcs_pkg::PH_ON: begin
					if (!nz_on[a_loc.pos]) begin
						srch_loc.ph = lbcs_pkg::PH_GAP;
					end
				end
				lbcs_pkg::PH_REPEAT: begin
					if (!rep_nz) begin
						srch_loc.pos = '0;
						srch_loc.ph  = nz_on[0] ? lbcs_pkg::PH_ON : lbcs_pkg::PH_GAP;
					end
				end
				default: begin
					srch_loc = a_loc;
				end
			endcase
		end else begin
			priority if ((a_loc.ph != lbcs_pkg::PH_REPEAT) && hit_from) begin
				srch_loc.ph  = lbcs_pkg::PH_ON;
				srch_loc.pos = idx_from;
			end else if (rep_nz) begin
				srch_loc.ph  = lbcs_pkg::PH_REPEAT;
				srch_loc.pos = last_pos;
			end else if (hit_zero) begin
				srch_loc.ph  = lbcs_pkg::PH_ON;
				srch_loc.pos = idx_zero;
			end else begin
				srch_found = 1'b0;
			end
		end
	end

	// every phase empty: land where the bounded settle run ends
	always_comb begin
		unique case (s_loc.ph)
			lbcs_pkg::PH_ON:     k0 = KW'({s_loc.pos, 1'b0});
			lbcs_pkg::PH_GAP:    k0 = KW'({s_loc.pos, 1'b1});
			lbcs_pkg::PH_REPEAT: k0 = two_len;
			default:             k0 = '0;
		endcase
		k_sum = (KW+1)'(k0) + (KW+1)'(wrap_off[len]);
		k_len = (KW+1)'(two_len) + (KW+1)'(1);
		kf    = (k_sum >= k_len) ? KW'(k_sum - k_len) : KW'(k_sum);
		if (kf == two_len) begin
			nf_loc.ph  = lbcs_pkg::PH_REPEAT;
			nf_loc.pos = last_pos;
		end else begin
			nf_loc.ph  = kf[0] ? lbcs_pkg::PH_GAP : lbcs_pkg::PH_ON;
			nf_loc.pos = PW'(kf >> 1);
		end
	end

	always_comb begin
		found = stay || srch_found;
		f_loc = stay ? s_loc : srch_loc;
		f_cnt = stay ? s_cnt : '0;
		unique case (f_loc.ph)
			lbcs_pkg::PH_ON:     f_dur = is_dot[f_loc.pos] ? dot_dur :
			                             (is_dash[f_loc.pos] ? dash_dur : '0);
			lbcs_pkg::PH_GAP:    f_dur = gap_dur;
			lbcs_pkg::PH_REPEAT: f_dur = rep_dur;
			default:             f_dur = '0;
		endcase
		inc_cnt   = f_cnt + TICK_WIDTH'(1);
		adv_f_loc = advance_loc(f_loc, len);
	end

	always_comb begin
		priority if (len_zero) begin
			res.led_on       = 1'b0;
			res.symbol_index = '0;
			res.phase        = lbcs_pkg::PH_REPEAT;
			phase_nxt        = lbcs_pkg::PH_ON;
			pos_nxt          = '0;
			cnt_nxt          = '0;
		end else if (!found) begin
			res.led_on       = 1'b0;
			res.symbol_index = 4'(nf_loc.pos);
			res.phase        = nf_loc.ph;
			phase_nxt        = nf_loc.ph;
			pos_nxt          = nf_loc.pos;
			cnt_nxt          = '0;
		end else begin
			res.led_on       = (f_loc.ph == lbcs_pkg::PH_ON);
			res.symbol_index = 4'(f_loc.pos);
			res.phase        = f_loc.ph;
			if (inc_cnt >= f_dur) begin
				phase_nxt = adv_f_loc.ph;
				pos_nxt   = adv_f_loc.pos;
				cnt_nxt   = '0;
			end else begin
				phase_nxt = f_loc.ph;
				pos_nxt   = f_loc.pos;
				cnt_nxt   = inc_cnt;
			end
		end
	end

endmodule

FILE: src/led_blink_code_sequencer.sv
// led blink code sequencer top level: one input word is one millisecond tick, and each
// tick gives one result word with the led level, the symbol shown and the phase (on, gap
// or repeat wait). A tick is taken every clock cycle while in_stall is low; it is held in
// the tick register, its result then goes into the output register, and results keep
// flowing at one per cycle while the output is not stalled. The whole tick, including
// skipping phases of zero length, is one pass through the step logic between the tick
// register and the result register, since the sequencer position feeds back from one
// tick to the next. Configuration writes are taken in any cycle (ready is always high)
// and must only happen while no tick is in flight.
`include "led_blink_code_sequencer_assert.svh"

module led_blink_code_sequencer #(
	parameter int MAX_SYMBOLS = 16,
	parameter int TICK_WIDTH  = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                restart,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                led_on,
	output logic [3:0]                          symbol_index,
	output logic [1:0]                          phase,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [lbcs_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [lbcs_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int PW = $clog2(MAX_SYMBOLS > 1 ? MAX_SYMBOLS : 2);

	logic [lbcs_pkg::DUR_W-1:0] dot_ticks_q, dash_ticks_q, gap_ticks_q, repeat_ticks_q;
	logic [lbcs_pkg::LEN_W-1:0] pattern_length_q;
	logic [lbcs_pkg::SYM_W-1:0] pattern_symbols_q;

	lbcs_pkg::phase_t      phase_q, phase_nxt;
	logic [PW-1:0]         pos_q, pos_nxt;
	logic [TICK_WIDTH-1:0] cnt_q, cnt_nxt;

	logic           valid_s1, restart_s1;
	logic           valid_s2;
	lbcs_pkg::res_t res_s2, res_nxt;
	logic           accept, s2_free, fire_s1;
	logic [1:0]     lit_sym;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_ticks_q       <= lbcs_pkg::DOT_TICKS_RST;
			dash_ticks_q      <= lbcs_pkg::DASH_TICKS_RST;
			gap_ticks_q       <= lbcs_pkg::GAP_TICKS_RST;
			repeat_ticks_q    <= lbcs_pkg::REPEAT_TICKS_RST;
			pattern_length_q  <= lbcs_pkg::PATTERN_LENGTH_RST;
			pattern_symbols_q <= lbcs_pkg::PATTERN_SYMBOLS_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				lbcs_pkg::REG_DOT_TICKS:       dot_ticks_q    <= cfg_data[lbcs_pkg::DUR_W-1:0];
				lbcs_pkg::REG_DASH_TICKS:      dash_ticks_q   <= cfg_data[lbcs_pkg::DUR_W-1:0];
				lbcs_pkg::REG_GAP_TICKS:       gap_ticks_q    <= cfg_data[lbcs_pkg::DUR_W-1:0];
				lbcs_pkg::REG_REPEAT_TICKS:    repeat_ticks_q <= cfg_data[lbcs_pkg::DUR_W-1:0];
				lbcs_pkg::REG_PATTERN_LENGTH:  pattern_length_q <= cfg_data[lbcs_pkg::LEN_W-1:0];
				lbcs_pkg::REG_PATTERN_SYMBOLS: pattern_symbols_q <= cfg_data[lbcs_pkg::SYM_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// result register drains or is empty, so the tick register can move on
	assign s2_free  = !valid_s2 || !out_stall;
	assign fire_s1  = valid_s1 && s2_free;
	assign in_stall = valid_s1 && !s2_free;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			restart_s1 <= restart;
		end
	end

	lbcs_step #(
		.MAX_SYMBOLS (MAX_SYMBOLS),
		.TICK_WIDTH  (TICK_WIDTH)
	) u_step (
		.restart         (restart_s1),
		.phase_cur       (phase_q),
		.pos_cur         (pos_q),
		.cnt_cur         (cnt_q),
		.dot_ticks       (dot_ticks_q),
		.dash_ticks      (dash_ticks_q),
		.gap_ticks       (gap_ticks_q),
		.repeat_ticks    (repeat_ticks_q),
		.pattern_length  (pattern_length_q),
		.pattern_symbols (pattern_symbols_q),
		.res             (res_nxt),
		.phase_nxt       (phase_nxt),
		.pos_nxt         (pos_nxt),
		.cnt_nxt         (cnt_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= lbcs_pkg::PH_ON;
			pos_q   <= '0;
			cnt_q   <= '0;
		end else if (fire_s1) begin
			phase_q <= phase_nxt;
			pos_q   <= pos_nxt;
			cnt_q   <= cnt_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (fire_s1) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			res_s2 <= res_nxt;
		end
	end

	assign out_valid    = valid_s2;
	assign led_on       = res_s2.led_on;
	assign symbol_index = res_s2.symbol_index;
	assign phase        = 2'(res_s2.phase);

	// symbol code of the word in the result register
	assign lit_sym = pattern_symbols_q[{res_s2.symbol_index, 1'b0} +: 2];

	`LBCS_ASSERT_IMPL(a_lit_only_on, clk, arst_n, valid_s2 && res_s2.led_on,
		res_s2.phase == lbcs_pkg::PH_ON, "led lit outside the on phase")
	`LBCS_ASSERT_IMPL(a_lit_symbol, clk, arst_n, valid_s2 && res_s2.led_on,
		(lit_sym == lbcs_pkg::SYM_DOT) || (lit_sym == lbcs_pkg::SYM_DASH),
		"led lit on a blank symbol")
	`LBCS_ASSERT_IMPL(a_empty_dark, clk, arst_n, valid_s2 && (pattern_length_q == '0),
		!res_s2.led_on && (res_s2.phase == lbcs_pkg::PH_REPEAT), "empty pattern not dark")
	`LBCS_ASSERT_NEXT(a_accept_fills, clk, arst_n, accept,
		valid_s1, "accepted tick word lost")

endmodule

FILE: test/led_blink_code_sequencer_checker.sv
// checker for the led blink code sequencer: tracks the channels, predicts each tick and compares
`timescale 1ns / 1ps

module led_blink_code_sequencer_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	input  logic                             in_stall,
	input  logic                             restart,
	input  logic                             out_valid,
	input  logic                             out_stall,
	input  logic                             led_on,
	input  logic [3:0]                       symbol_index,
	input  logic [1:0]                       phase,
	input  logic                             cfg_valid,
	input  logic                             cfg_ready,
	input  logic [lbcs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [lbcs_pkg::CFG_DATA_W-1:0]  cfg_data,
	output int                               pending,
	output int                               errors
);

	// walk through both phases of every symbol plus the repeat wait before giving up
	localparam int SKIP_LIMIT = 2 * lbcs_pkg::SYM_SLOTS + 4;

	logic [lbcs_pkg::DUR_W-1:0] dot_len, dash_len, gap_len, pause_len;
	logic [lbcs_pkg::LEN_W-1:0] code_len;
	logic [lbcs_pkg::SYM_W-1:0] code_syms;

	lbcs_pkg::phase_t           ph;
	logic [3:0]                 pos;
	logic [lbcs_pkg::DUR_W-1:0] cnt;

	lbcs_pkg::res_t led_words_due[$];
	int             bad;

	function automatic logic [lbcs_pkg::DUR_W-1:0] phase_len();
		logic [1:0] sym;
		sym = code_syms[2 * pos +: 2];
		case (ph)
			lbcs_pkg::PH_ON: begin
				// blank and code three have no lit part
				if (sym == lbcs_pkg::SYM_DOT)
					return dot_len;
				else if (sym == lbcs_pkg::SYM_DASH)
					return dash_len;
				else
					return '0;
			end
			lbcs_pkg::PH_GAP: return gap_len;
			default: return pause_len;
		endcase
	endfunction

	function automatic void next_phase(input int n);
		cnt = '0;
		case (ph)
			lbcs_pkg::PH_ON: ph = lbcs_pkg::PH_GAP;
			lbcs_pkg::PH_GAP: begin
				if (int'(pos) + 1 < n) begin
					pos = pos + 1'b1;
					ph  = lbcs_pkg::PH_ON;
				end else begin
					ph = lbcs_pkg::PH_REPEAT;
				end
			end
			default: begin
				ph  = lbcs_pkg::PH_ON;
				pos = '0;
			end
		endcase
	endfunction

	function automatic lbcs_pkg::res_t next_led_word(input logic rs);
		int             n;
		int             i;
		bit             hit;
		lbcs_pkg::res_t r;
		n = (code_len > lbcs_pkg::SYM_SLOTS) ? lbcs_pkg::SYM_SLOTS : int'(code_len);
		if (rs || n == 0 || int'(pos) >= n) begin
			ph  = lbcs_pkg::PH_ON;
			pos = '0;
			cnt = '0;
		end
		if (n == 0) begin
			r.led_on       = 1'b0;
			r.symbol_index = '0;
			r.phase        = lbcs_pkg::PH_REPEAT;
			return r;
		end
		// phases of zero length pass without using the tick
		hit = 1'b0;
		for (i = 0; i < SKIP_LIMIT && !hit; i++) begin
			if (cnt < phase_len())
				hit = 1'b1;
			else
				next_phase(n);
		end
		r.led_on       = hit && ph == lbcs_pkg::PH_ON;
		r.symbol_index = pos;
		r.phase        = ph;
		if (hit) begin
			cnt = cnt + 1'b1;
			if (cnt >= phase_len())
				next_phase(n);
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		lbcs_pkg::res_t want;
		if (!arst_n) begin
			dot_len   = lbcs_pkg::DOT_TICKS_RST;
			dash_len  = lbcs_pkg::DASH_TICKS_RST;
			gap_len   = lbcs_pkg::GAP_TICKS_RST;
			pause_len = lbcs_pkg::REPEAT_TICKS_RST;
			code_len  = lbcs_pkg::PATTERN_LENGTH_RST;
			code_syms = lbcs_pkg::PATTERN_SYMBOLS_RST;
			ph        = lbcs_pkg::PH_ON;
			pos       = '0;
			cnt       = '0;
			bad       = 0;
			led_words_due.delete();
			pending <= 0;
			errors  <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (led_words_due.size() == 0) begin
					$error("result word with nothing expected");
					bad++;
				end else begin
					want = led_words_due.pop_front();
					if (led_on !== want.led_on) begin
						$error("led_on: expected %0d, actual %0d", want.led_on, led_on);
						bad++;
					end
					if (symbol_index !== want.symbol_index) begin
						$error("symbol_index: expected %0d, actual %0d",
							want.symbol_index, symbol_index);
						bad++;
					end
					if (phase !== want.phase) begin
						$error("phase: expected %0d, actual %0d", want.phase, phase);
						bad++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					lbcs_pkg::REG_DOT_TICKS:
						dot_len   = cfg_data[lbcs_pkg::DUR_W-1:0];
					lbcs_pkg::REG_DASH_TICKS:
						dash_len  = cfg_data[lbcs_pkg::DUR_W-1:0];
					lbcs_pkg::REG_GAP_TICKS:
						gap_len   = cfg_data[lbcs_pkg::DUR_W-1:0];
					lbcs_pkg::REG_REPEAT_TICKS:
						pause_len = cfg_data[lbcs_pkg::DUR_W-1:0];
					lbcs_pkg::REG_PATTERN_LENGTH:
						code_len  = cfg_data[lbcs_pkg::LEN_W-1:0];
					lbcs_pkg::REG_PATTERN_SYMBOLS:
						code_syms = cfg_data[lbcs_pkg::SYM_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				led_words_due.push_back(next_led_word(restart));
			pending <= led_words_due.size();
			errors  <= bad;
		end
	end

endmodule

FILE: test/led_blink_code_sequencer_test.sv
// top of the led blink code sequencer testbench: clock, reset, ticks, configuration and verdict
`timescale 1ns / 1ps

module led_blink_code_sequencer_test;

	localparam int NUM_REGS    = 6;
	localparam int TICK_TARGET = 1500;
	localparam int CALM_AFTER  = 1300;
	localparam int SQUEEZE_AT  = 600;
	localparam int HOLD_CYCLES = 64;
	localparam int DEAD_LIMIT  = 2000;

	logic                            clk;
	logic                            arst_n;
	logic                            in_valid;
	logic                            in_stall;
	logic                            restart;
	logic                            out_valid;
	logic                            out_stall;
	logic                            led_on;
	logic [3:0]                      symbol_index;
	logic [1:0]                      phase;
	logic                            cfg_valid;
	logic                            cfg_ready;
	logic [lbcs_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [lbcs_pkg::CFG_DATA_W-1:0] cfg_data;

	int pending;
	int errors;
	int sent = 0;
	int dead_cycles = 0;
	bit calm = 1'b0;
	bit squeeze = 1'b0;
	bit squeezed = 1'b0;

	logic [lbcs_pkg::CFG_DATA_W-1:0] reg_val [NUM_REGS];

	led_blink_code_sequencer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.restart      (restart),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.led_on       (led_on),
		.symbol_index (symbol_index),
		.phase        (phase),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	led_blink_code_sequencer_checker led_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.restart      (restart),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.led_on       (led_on),
		.symbol_index (symbol_index),
		.phase        (phase),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.pending      (pending),
		.errors       (errors)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// no word moving on any channel for too long means the block hung
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			dead_cycles <= 0;
		else
			dead_cycles <= dead_cycles + 1;
		if (dead_cycles >= DEAD_LIMIT) begin
			$display("led_blink_code_sequencer_test: done, errors");
			$finish;
		end
	end

	// result side: short random stalls, one long hold-off on request
	initial begin
		out_stall = 1'b0;
		@(posedge clk);
		forever begin
			if (squeeze) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
				squeeze = 1'b0;
				@(posedge clk);
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 7)) @(posedge clk);
				out_stall <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end else begin
				out_stall <= 1'b0;
				@(posedge clk);
			end
		end
	end

	function automatic logic [lbcs_pkg::CFG_DATA_W-1:0] pick_ticks();
		case ($urandom_range(0, 19))
			0: return '0;
			1: return 32'd65535;
			2: return $urandom_range(1, 65535);
			default: return $urandom_range(1, 6);
		endcase
	endfunction

	task automatic settle();
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic write_regs(input logic [NUM_REGS-1:0] sel);
		int i;
		settle();
		for (i = 0; i < NUM_REGS; i++) begin
			if (sel[i]) begin
				cfg_valid <= 1'b1;
				cfg_index <= lbcs_pkg::reg_idx_t'(i);
				cfg_data  <= reg_val[i];
				do @(posedge clk); while (!cfg_ready);
			end
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic send_tick(input logic r);
		if (!calm && !squeeze && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		in_valid <= 1'b1;
		restart  <= r;
		do @(posedge clk); while (in_stall);
		sent++;
	endtask

	task automatic send_run(input int n, input int restart_pct);
		repeat (n)
			send_tick($urandom_range(0, 99) < restart_pct);
		in_valid <= 1'b0;
	endtask

	task automatic set_regs(input logic [lbcs_pkg::CFG_DATA_W-1:0] dot, dash, gap, pause,
			len, syms);
		reg_val[lbcs_pkg::REG_DOT_TICKS]       = dot;
		reg_val[lbcs_pkg::REG_DASH_TICKS]      = dash;
		reg_val[lbcs_pkg::REG_GAP_TICKS]       = gap;
		reg_val[lbcs_pkg::REG_REPEAT_TICKS]    = pause;
		reg_val[lbcs_pkg::REG_PATTERN_LENGTH]  = len;
		reg_val[lbcs_pkg::REG_PATTERN_SYMBOLS] = syms;
	endtask

	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		restart   = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = lbcs_pkg::REG_DOT_TICKS;
		cfg_data  = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset pattern, with restarts
		repeat (3) send_tick(1'b0);
		repeat (2) send_tick(1'b1);
		send_run(1, 0);

		// shortest durations over blank, dot, dash and code three
		set_regs(1, 2, 1, 1, 4, 32'hE4E4_E4E4);
		write_regs('1);
		send_run(9, 0);

		// empty pattern
		set_regs(1, 2, 1, 1, 0, 32'hE4E4_E4E4);
		write_regs('1);
		send_tick(1'b0);
		send_run(1, 100);

		// oversized length, every phase of zero length: led stays dark
		set_regs(0, 0, 0, 0, 31, 0);
		write_regs('1);
		send_run(2, 0);

		// longest durations
		set_regs(65535, 65535, 65535, 65535, 16, 32'hFFFF_FFFD);
		write_regs('1);
		send_run(2, 0);

		while (sent < TICK_TARGET) begin
			reg_val[lbcs_pkg::REG_DOT_TICKS]    = pick_ticks();
			reg_val[lbcs_pkg::REG_DASH_TICKS]   = pick_ticks();
			reg_val[lbcs_pkg::REG_GAP_TICKS]    = pick_ticks();
			reg_val[lbcs_pkg::REG_REPEAT_TICKS] = pick_ticks();
			case ($urandom_range(0, 9))
				0: reg_val[lbcs_pkg::REG_PATTERN_LENGTH] = 0;
				1: reg_val[lbcs_pkg::REG_PATTERN_LENGTH] = lbcs_pkg::SYM_SLOTS;
				2: reg_val[lbcs_pkg::REG_PATTERN_LENGTH] =
					$urandom_range(lbcs_pkg::SYM_SLOTS + 1, 31);
				default: reg_val[lbcs_pkg::REG_PATTERN_LENGTH] = $urandom_range(1, 6);
			endcase
			reg_val[lbcs_pkg::REG_PATTERN_SYMBOLS] = $urandom();
			if (sent >= CALM_AFTER)
				calm = 1'b1;
			write_regs(NUM_REGS'($urandom_range(0, 2 ** NUM_REGS - 1)));
			if (!squeezed && sent >= SQUEEZE_AT) begin
				// keep offering ticks while the result side holds off
				squeezed = 1'b1;
				squeeze  = 1'b1;
				send_run(90, 5);
			end else begin
				send_run($urandom_range(10, 60), ($urandom_range(0, 3) == 0) ? 30 : 3);
			end
		end

		settle();
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("led_blink_code_sequencer_test: done, clean");
		else
			$display("led_blink_code_sequencer_test: done, errors");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+src
src/lbcs_pkg.sv
src/lbcs_step.sv
src/led_blink_code_sequencer.sv
test/led_blink_code_sequencer_checker.sv
test/led_blink_code_sequencer_test.sv
